// File: rtl/weighted_scale_quantizer_defines.svh
// Assertion macros for the weighted scale quantizer.
`ifndef WEIGHTED_SCALE_QUANTIZER_DEFINES_SVH
`define WEIGHTED_SCALE_QUANTIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsq assertion failed");

// Next-cycle implication, checked outside reset.
`define WSQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsq assertion failed");

`endif

// File: rtl/wsq_pkg.sv
// Types and constants shared by the weighted scale quantizer modules.
package wsq_pkg;

	localparam int XW       = 16;    // input pitch width
	localparam int CandW    = 17;    // candidate and octave base width, signed
	localparam int DistW    = 14;    // candidate distance width
	localparam int WtW      = 9;     // weight width
	localparam int CvW      = 14;    // output pitch width
	localparam int SemW     = 4;     // semitone width
	localparam int CfgW     = 54;    // configuration register width
	localparam int CfgIdxW  = 2;     // configuration index width
	localparam int NumSemi  = 12;
	localparam int NumOct   = 3;     // octave below, same octave, octave above
	localparam int NumCells = NumSemi * NumOct;
	localparam int SemiPerReg = 6;

	localparam int UnitsPerOct  = 3072;
	localparam int UnitsPerSemi = 256;
	localparam int MaxWeight    = 256;
	localparam int OutMax       = 15360;
	localparam int RecipThird   = 171;   // ceil(512 / 3)
	localparam int RecipShift   = 9;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] RegWeightsLow  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegWeightsHigh = 2'd1;

	// How the result was chosen
	typedef enum logic [1:0] {
		KindMatch = 2'd0,
		KindNear  = 2'd1,
		KindPass  = 2'd2
	} kind_t;

	// Search state handed from cell to cell
	typedef struct packed {
		logic signed [XW-1:0]    x;
		logic signed [CandW-1:0] base;
		logic                    near_found;
		logic [DistW-1:0]        near_d;
		logic signed [CandW-1:0] near_v;
		logic                    matched;
		logic [WtW-1:0]          best_w;
		logic [WtW-1:0]          best_d;
		logic signed [CandW-1:0] best_v;
	} track_t;

	// Candidate offset from the octave base for cell c (semitone c/3, octave c%3 - 1)
	function automatic logic signed [CandW-1:0] cell_offset(input int c);
		int off;
		begin
			off = ((c % NumOct) - 1) * UnitsPerOct + (c / NumOct) * UnitsPerSemi;
			cell_offset = CandW'(off);
		end
	endfunction

endpackage

// File: rtl/wsq_front.sv
// Entry stage: split the input pitch into its truncated octave base.
module wsq_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic signed [wsq_pkg::XW-1:0] cv_in,
	output logic                          valid_s1,
	output wsq_pkg::track_t               trk_s1
);

	logic [wsq_pkg::XW:0]      mag;
	logic [6:0]                oct_hi;
	logic [12:0]               prod;
	logic [3:0]                oct_abs;
	logic [15:0]               base_abs;
	logic signed [wsq_pkg::CandW-1:0] base;
	wsq_pkg::track_t           trk_d;

	// Octave = |x| / 3072 = (|x| >> 10) / 3, signed back toward zero
	always_comb begin
		mag      = cv_in[wsq_pkg::XW-1] ? (17'd0 - {cv_in[wsq_pkg::XW-1], cv_in})
		                               : {1'b0, cv_in};
		oct_hi   = mag[16:10];
		prod     = 13'(oct_hi * 8'(wsq_pkg::RecipThird));
		oct_abs  = prod[12:wsq_pkg::RecipShift];
		base_abs = 16'(oct_abs * 12'(wsq_pkg::UnitsPerOct));
		base     = cv_in[wsq_pkg::XW-1] ? (17'sd0 - $signed({1'b0, base_abs}))
		                               : $signed({1'b0, base_abs});
	end

	// Seed an empty search
	always_comb begin
		trk_d            = '0;
		trk_d.x          = cv_in;
		trk_d.base       = base;
		trk_d.near_v     = wsq_pkg::CandW'(cv_in);
		trk_d.best_v     = wsq_pkg::CandW'(cv_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s1 <= trk_d;
		end
	end

endmodule

// File: rtl/wsq_cell.sv
// One search cell: score a single candidate and pass the best so far onward.
module wsq_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_valid,
	input  wsq_pkg::track_t                     in_trk,
	input  logic [wsq_pkg::WtW-1:0]             weight,
	input  logic signed [wsq_pkg::CandW-1:0]    offset,
	output logic                                out_valid,
	output wsq_pkg::track_t                     out_trk
);

	logic signed [wsq_pkg::CandW-1:0] cand;
	logic signed [wsq_pkg::CandW:0]   diff;
	logic [wsq_pkg::CandW:0]          dist_full;
	logic [wsq_pkg::DistW-1:0]        cand_dist;
	logic [wsq_pkg::WtW:0]            bd1;
	logic [wsq_pkg::WtW:0]            d1;
	logic [2*wsq_pkg::WtW:0]          lhs;
	logic [2*wsq_pkg::WtW:0]          rhs;
	logic                             en;
	logic                             closer;
	logic                             hit;
	logic                             better;
	wsq_pkg::track_t                  trk_d;

	// Distance from the input to this candidate
	always_comb begin
		cand      = in_trk.base + offset;
		diff      = (wsq_pkg::CandW+1)'(in_trk.x) - (wsq_pkg::CandW+1)'(cand);
		dist_full = diff[wsq_pkg::CandW] ? 18'(-diff) : 18'(diff);
		cand_dist = dist_full[wsq_pkg::DistW-1:0];
	end

	// Compare scores weight/(dist+1) by cross-multiplication
	always_comb begin
		en     = (weight != '0);
		closer = en && (!in_trk.near_found || (cand_dist < in_trk.near_d));
		hit    = en && (cand_dist <= wsq_pkg::DistW'(weight));
		bd1    = {1'b0, in_trk.best_d} + 10'd1;
		d1     = {1'b0, cand_dist[wsq_pkg::WtW-1:0]} + 10'd1;
		lhs    = 19'(weight * bd1);
		rhs    = 19'(in_trk.best_w * d1);
		better = hit && (!in_trk.matched || (lhs > rhs));
	end

	// Update the nearest and best-match records
	always_comb begin
		trk_d = in_trk;
		if (closer) begin
			trk_d.near_found = 1'b1;
			trk_d.near_d     = cand_dist;
			trk_d.near_v     = cand;
		end
		if (better) begin
			trk_d.matched = 1'b1;
			trk_d.best_w  = weight;
			trk_d.best_d  = cand_dist[wsq_pkg::WtW-1:0];
			trk_d.best_v  = cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_trk <= trk_d;
		end
	end

endmodule

// File: rtl/weighted_scale_quantizer.sv
// Weighted 12-tone pitch quantizer: entry stage, chain of 36 search cells, output stages.
//
// Input channel s_*: one signed pitch sample per transaction, 3072 units per volt.
// Output channel m_*: the snapped pitch (0..15360), its semitone and, in m_tuser,
// whether it came from a weighted match, the nearest fallback or a passthrough.
// Configuration channel cfg_*: index 0 writes semitone weights 0..5, index 1
// writes 6..11, nine bits each; other indexes are ignored. cfg_ready is always
// high. Write weights only while no sample is in flight.
// Each sample walks through 36 cells, one per candidate (semitone ascending,
// octave below, same, above), on its way from input transaction to m_tvalid:
// one entry stage, 36 cells, a select/clamp stage and the output register.
// Throughput is one sample per cycle while the receiver does not stall.
// When the receiver stalls with m_tvalid high, the whole chain holds and
// s_tready drops until the output transaction completes.
// Reset clears all weights (every semitone disabled, so samples pass through
// clamped) and empties the pipeline.
`include "weighted_scale_quantizer_defines.svh"

module weighted_scale_quantizer (
	input  logic                              clk,
	input  logic                              arst_n,
	// tdata: cv_in[15:0]
	input  logic [15:0]                       s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tdata: cv_out[13:0], semitone[17:14], zero pad[23:18]
	output logic [23:0]                       m_tdata,
	// tuser: match_kind[1:0]
	output logic [1:0]                        m_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wsq_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [wsq_pkg::CfgW-1:0]          cfg_data
);

	logic [wsq_pkg::CfgW-1:0]  weights_low_q;
	logic [wsq_pkg::CfgW-1:0]  weights_high_q;
	logic [wsq_pkg::WtW-1:0]   weight [wsq_pkg::NumSemi];
	logic                      any_en;
	logic                      adv;
	logic                      vld [wsq_pkg::NumCells+1];
	wsq_pkg::track_t           trk [wsq_pkg::NumCells+1];

	logic signed [wsq_pkg::CandW-1:0] sel;
	wsq_pkg::kind_t                   kind_sel;
	logic [wsq_pkg::CvW-1:0]          cv_clamp;

	logic                      valid_o1;
	logic [wsq_pkg::CvW-1:0]   cv_o1;
	wsq_pkg::kind_t            kind_o1;

	logic [3:0]                oct_hi;
	logic [11:0]               prod;
	logic [2:0]                oct_q;
	logic [wsq_pkg::CvW-1:0]   in_oct;
	logic [12:0]               rounded;
	logic [wsq_pkg::SemW-1:0]  semi_raw;
	logic [wsq_pkg::SemW-1:0]  semi;

	logic                      m_tvalid_q;
	logic [wsq_pkg::CvW-1:0]   cv_q;
	logic [wsq_pkg::SemW-1:0]  semi_q;
	wsq_pkg::kind_t            kind_q;

	// Hold the whole chain while a finished result waits
	assign adv       = !m_tvalid_q || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// Weight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_low_q  <= '0;
			weights_high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wsq_pkg::RegWeightsLow:  weights_low_q  <= cfg_data;
				wsq_pkg::RegWeightsHigh: weights_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate each weight field at 256
	always_comb begin
		any_en = 1'b0;
		for (int s = 0; s < wsq_pkg::NumSemi; s++) begin
			logic [wsq_pkg::WtW-1:0] raw;
			raw = (s < wsq_pkg::SemiPerReg)
				? weights_low_q[(s % wsq_pkg::SemiPerReg) * wsq_pkg::WtW +: wsq_pkg::WtW]
				: weights_high_q[(s % wsq_pkg::SemiPerReg) * wsq_pkg::WtW +: wsq_pkg::WtW];
			weight[s] = (raw > wsq_pkg::WtW'(wsq_pkg::MaxWeight))
				? wsq_pkg::WtW'(wsq_pkg::MaxWeight) : raw;
			any_en = any_en | (raw != '0);
		end
	end

	wsq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.cv_in    (s_tdata[wsq_pkg::XW-1:0]),
		.valid_s1 (vld[0]),
		.trk_s1   (trk[0])
	);

	// Search chain: one cell per candidate
	for (genvar c = 0; c < wsq_pkg::NumCells; c++) begin : g_cell
		wsq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (vld[c]),
			.in_trk    (trk[c]),
			.weight    (weight[c / wsq_pkg::NumOct]),
			.offset    (wsq_pkg::cell_offset(c)),
			.out_valid (vld[c+1]),
			.out_trk   (trk[c+1])
		);
	end

	// Pick the result and clamp to 0..5 V
	always_comb begin
		if (!any_en) begin
			sel      = wsq_pkg::CandW'(trk[wsq_pkg::NumCells].x);
			kind_sel = wsq_pkg::KindPass;
		end else if (trk[wsq_pkg::NumCells].matched) begin
			sel      = trk[wsq_pkg::NumCells].best_v;
			kind_sel = wsq_pkg::KindMatch;
		end else begin
			sel      = trk[wsq_pkg::NumCells].near_v;
			kind_sel = wsq_pkg::KindNear;
		end
		if (sel < 0) begin
			cv_clamp = '0;
		end else if (sel > wsq_pkg::CandW'(wsq_pkg::OutMax)) begin
			cv_clamp = wsq_pkg::CvW'(wsq_pkg::OutMax);
		end else begin
			cv_clamp = sel[wsq_pkg::CvW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o1 <= 1'b0;
		end else if (adv) begin
			valid_o1 <= vld[wsq_pkg::NumCells];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cv_o1   <= cv_clamp;
			kind_o1 <= kind_sel;
		end
	end

	// Semitone: ((cv mod 3072) + 128) / 256, wrapped at 12
	always_comb begin
		oct_hi   = cv_o1[13:10];
		prod     = 12'(oct_hi * 8'(wsq_pkg::RecipThird));
		oct_q    = prod[11:wsq_pkg::RecipShift];
		in_oct   = cv_o1 - wsq_pkg::CvW'(oct_q * 12'(wsq_pkg::UnitsPerOct));
		rounded  = 13'(in_oct[11:0]) + 13'(wsq_pkg::UnitsPerSemi / 2);
		semi_raw = rounded[11:8];
		semi     = (semi_raw == wsq_pkg::SemW'(wsq_pkg::NumSemi)) ? '0 : semi_raw;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= valid_o1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cv_q   <= cv_o1;
			semi_q <= semi;
			kind_q <= kind_o1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, semi_q, cv_q};
	assign m_tuser  = kind_q;

	// Checks
	`WSQ_ASSERT_NOW(a_out_range, m_tvalid, (cv_q <= wsq_pkg::CvW'(wsq_pkg::OutMax)) && (semi_q < wsq_pkg::SemW'(wsq_pkg::NumSemi)))
	`WSQ_ASSERT_NEXT(a_chain_to_out, vld[wsq_pkg::NumCells] && adv, valid_o1)
	`WSQ_ASSERT_NEXT(a_in_to_chain, s_tvalid && s_tready, vld[0])

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the weighted scale quantizer: stimulus, prediction, checks.
`timescale 1ns / 100ps

module tb_top;

	localparam int DrainCycles = 45;    // pipeline latency plus margin
	localparam int StallLimit  = 3000;  // cycles with no transaction before giving up
	localparam int HoldCycles  = 300;   // long receiver hold-off
	localparam logic [wsq_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
	localparam logic [wsq_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;
	localparam logic [wsq_pkg::CfgW-1:0]    AllOnes   = {wsq_pkg::CfgW{1'b1}};

	// Expected fields of one quantized result
	typedef struct packed {
		logic [wsq_pkg::CvW-1:0]  cv;
		logic [wsq_pkg::SemW-1:0] semi;
		wsq_pkg::kind_t           kind;
	} snap_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic [15:0]                  s_tdata = '0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [23:0]                  m_tdata;
	logic [1:0]                   m_tuser;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [wsq_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [wsq_pkg::CfgW-1:0]     cfg_data = '0;

	// Predictor copy of the weight registers
	logic [wsq_pkg::CfgW-1:0]     wt_low = '0;
	logic [wsq_pkg::CfgW-1:0]     wt_high = '0;

	logic [15:0]         pitch_q[$];
	snap_t               snap_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;
	int hold_left = 0;
	int err_count = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int kind_count[3] = '{0, 0, 0};
	int settings_used = 1;
	int stall_cycles = 0;

	weighted_scale_quantizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock: 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Snap one pitch to the weighted scale under the given weights
	function automatic snap_t snap_pitch(input logic signed [15:0] cv_in,
			input logic [wsq_pkg::CfgW-1:0] lo, input logic [wsq_pkg::CfgW-1:0] hi);
		int x, octv, s, k, w, cand, d, pick, near_d, near_v, best_v;
		longint best_w, best_d;
		bit any, matched, near_found;
		logic [wsq_pkg::WtW-1:0] field;
		snap_t q;
		begin
			x = cv_in;
			octv = x / wsq_pkg::UnitsPerOct;
			any = 0;
			matched = 0;
			near_found = 0;
			near_d = 0;
			near_v = x;
			best_v = x;
			best_w = 0;
			best_d = 0;
			for (s = 0; s < wsq_pkg::NumSemi; s++) begin
				field = (s < wsq_pkg::SemiPerReg)
					? lo[(s % wsq_pkg::SemiPerReg) * wsq_pkg::WtW +: wsq_pkg::WtW]
					: hi[(s % wsq_pkg::SemiPerReg) * wsq_pkg::WtW +: wsq_pkg::WtW];
				w = (field > wsq_pkg::MaxWeight) ? wsq_pkg::MaxWeight : field;
				if (w != 0) begin
					any = 1;
					for (k = -1; k <= 1; k++) begin
						cand = (octv + k) * wsq_pkg::UnitsPerOct + s * wsq_pkg::UnitsPerSemi;
						d = (x > cand) ? x - cand : cand - x;
						// nearest candidate, first one keeps a tie
						if (!near_found || d < near_d) begin
							near_found = 1;
							near_d = d;
							near_v = cand;
						end
						// weighted score w/(d+1), compared by cross-multiplication
						if (d <= w && (!matched
								|| longint'(w) * (best_d + 1) > best_w * (longint'(d) + 1))) begin
							matched = 1;
							best_w = w;
							best_d = d;
							best_v = cand;
						end
					end
				end
			end
			if (!any) begin
				pick = x;
				q.kind = wsq_pkg::KindPass;
			end else if (matched) begin
				pick = best_v;
				q.kind = wsq_pkg::KindMatch;
			end else begin
				pick = near_v;
				q.kind = wsq_pkg::KindNear;
			end
			if (pick < 0) pick = 0;
			if (pick > wsq_pkg::OutMax) pick = wsq_pkg::OutMax;
			q.cv = pick[wsq_pkg::CvW-1:0];
			q.semi = wsq_pkg::SemW'((((pick % wsq_pkg::UnitsPerOct) + 128)
				/ wsq_pkg::UnitsPerSemi) % wsq_pkg::NumSemi);
			snap_pitch = q;
		end
	endfunction

	// Random weight set: many disabled, mostly in range, some above range when maxw allows
	function automatic logic [wsq_pkg::CfgW-1:0] rand_weights(input int maxw);
		logic [wsq_pkg::CfgW-1:0] r;
		int f, roll, val;
		begin
			r = '0;
			for (f = 0; f < wsq_pkg::SemiPerReg; f++) begin
				roll = $urandom_range(99);
				if (roll < 25)
					val = 0;
				else if (roll < 85 || maxw < wsq_pkg::MaxWeight)
					val = $urandom_range(maxw, 1);
				else
					val = $urandom_range(511, 257);
				r[f * wsq_pkg::WtW +: wsq_pkg::WtW] = val[wsq_pkg::WtW-1:0];
			end
			rand_weights = r;
		end
	endfunction

	function automatic logic [15:0] rand_pitch();
		int roll, v;
		begin
			roll = $urandom_range(99);
			if (roll < 55)
				v = int'($urandom_range(61440)) - 30720;
			else if (roll < 85)
				v = int'($urandom_range(60)) * wsq_pkg::UnitsPerSemi
					+ int'($urandom_range(600)) - 300;
			else
				v = $urandom;
			rand_pitch = v[15:0];
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		begin
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
			err_count++;
		end
	endtask

	task automatic queue_random(input int n);
		int i;
		begin
			for (i = 0; i < n; i++)
				pitch_q.push_back(rand_pitch());
		end
	endtask

	// Write one register once the previous write has dropped valid
	task automatic write_reg(input logic [wsq_pkg::CfgIdxW-1:0] idx,
			input logic [wsq_pkg::CfgW-1:0] data);
		begin
			@(posedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			if (idx == wsq_pkg::RegWeightsLow)
				wt_low = data;
			else if (idx == wsq_pkg::RegWeightsHigh)
				wt_high = data;
			cfg_valid <= 1'b0;
		end
	endtask

	// Wait until everything sent has come back, then let the pipeline drain
	task automatic settle();
		begin
			// check between edges so the driver's updates have landed
			while (pitch_q.size() > 0 || s_tvalid || snap_q.size() > 0)
				@(negedge clk);
			repeat (DrainCycles) @(posedge clk);
		end
	endtask

	// Sender: offer queued pitches, hold each until its transaction completes
	always @(posedge clk) begin : drive
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				snap_q.push_back(snap_pitch(s_tdata, wt_low, wt_high));
				samples_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pitch_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= pitch_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: random stalls, plus one long hold-off on request
	always @(posedge clk) begin : receive
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (long_hold_go && !long_hold_done) begin
			m_tready <= 1'b0;
			hold_left <= HoldCycles;
			long_hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin : monitor
		snap_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (snap_q.size() == 0) begin
				report_mismatch("unexpected result, cv_out", m_tdata[13:0], -1);
			end else begin
				want = snap_q.pop_front();
				if (m_tdata[13:0] !== want.cv)
					report_mismatch("cv_out", m_tdata[13:0], want.cv);
				if (m_tdata[17:14] !== want.semi)
					report_mismatch("semitone", m_tdata[17:14], want.semi);
				if (m_tdata[23:18] !== 6'd0)
					report_mismatch("tdata pad", m_tdata[23:18], 0);
				if (m_tuser !== want.kind)
					report_mismatch("match_kind", m_tuser, want.kind);
				kind_count[want.kind]++;
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallLimit) begin
				$display("[%0t] no transaction for %0d cycles", $realtime, StallLimit);
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// Test sequence
	initial begin : sequencer
		int semi_pick;
		logic [wsq_pkg::CfgW-1:0] single;
		int edge_cases[12];
		edge_cases = '{-32768, -30720, -1, 0, 127, 128, 3071, 3072, 15360, 15361, 30720, 32767};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// After reset every semitone is off: field extremes pass through clamped
		send_idle_pct = 32;
		recv_idle_pct = 84;
		foreach (edge_cases[i])
			pitch_q.push_back(edge_cases[i][15:0]);
		settle();

		// Mixed scale with full, partial, minimal and above-range weights
		write_reg(wsq_pkg::RegWeightsLow, {9'd1, 9'd511, 9'd0, 9'd100, 9'd0, 9'd256});
		write_reg(wsq_pkg::RegWeightsHigh, {9'd300, 9'd0, 9'd40, 9'd0, 9'd256, 9'd0});
		settings_used++;
		foreach (edge_cases[i])
			pitch_q.push_back(edge_cases[i][15:0]);
		queue_random(60);
		settle();

		// Lower half fully saturated, upper half off; spare indexes must be ignored
		send_idle_pct = 84;
		recv_idle_pct = 32;
		write_reg(wsq_pkg::RegWeightsLow, AllOnes);
		write_reg(wsq_pkg::RegWeightsHigh, '0);
		write_reg(RegSpareA, AllOnes);
		write_reg(RegSpareB, {wsq_pkg::CfgW/2{2'b01}});
		settings_used++;
		queue_random(60);
		settle();

		write_reg(wsq_pkg::RegWeightsLow, rand_weights(wsq_pkg::MaxWeight));
		write_reg(wsq_pkg::RegWeightsHigh, rand_weights(wsq_pkg::MaxWeight));
		settings_used++;
		queue_random(80);
		settle();

		// Tiny weights favor the nearest fallback; hold the receiver to fill the pipe
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(wsq_pkg::RegWeightsLow, rand_weights(8));
		write_reg(wsq_pkg::RegWeightsHigh, rand_weights(8));
		settings_used++;
		long_hold_go = 1'b1;
		queue_random(80);
		settle();

		// One semitone enabled at the smallest weight
		semi_pick = $urandom_range(wsq_pkg::SemiPerReg - 1);
		single = '0;
		single[semi_pick * wsq_pkg::WtW] = 1'b1;
		write_reg(wsq_pkg::RegWeightsLow, '0);
		write_reg(wsq_pkg::RegWeightsHigh, single);
		settings_used++;
		queue_random(60);
		settle();

		// Every field at its top value
		write_reg(wsq_pkg::RegWeightsLow, AllOnes);
		write_reg(wsq_pkg::RegWeightsHigh, AllOnes);
		settings_used++;
		queue_random(80);
		settle();

		$display("Covered %0d samples under %0d weight settings, %0d results checked.",
			samples_sent, settings_used, results_seen);
		$display("Results by kind: %0d weighted, %0d nearest, %0d passthrough; long hold-off %s.",
			kind_count[wsq_pkg::KindMatch], kind_count[wsq_pkg::KindNear],
			kind_count[wsq_pkg::KindPass], long_hold_done ? "done" : "missed");
		if (err_count == 0 && snap_q.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("%0d mismatches, %0d results outstanding", err_count, snap_q.size());
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
